FILE: sv/dfr_pkg.sv
// dfr_pkg: shared constants, status codes and types of the delimited frame receiver
// used by every module of the block but dfr_ram; depends on nothing
package dfr_pkg;

  localparam int BUFFER_DEPTH = 128;
  localparam int FRAME_LEN    = 16;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH);
  localparam int IDX_W        = $clog2(FRAME_LEN);

  localparam logic [7:0] HDR0 = 8'h44;  // 'D'
  localparam logic [7:0] HDR1 = 8'h41;  // 'A'
  localparam logic [7:0] TRL0 = 8'h54;  // 'T'
  localparam logic [7:0] TRL1 = 8'h41;  // 'A'
  localparam logic [7:0] TRL2 = 8'h0D;  // CR
  localparam logic [7:0] TRL3 = 8'h0A;  // LF

  typedef enum logic [1:0] {
    ST_FRAME       = 2'd0,
    ST_BAD_HEADER  = 2'd1,
    ST_BAD_LENBYTE = 2'd2,
    ST_BAD_SIZE    = 2'd3
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_LOAD = 3'b100
  } back_state_t;

endpackage

FILE: sv/dfr_ram.sv
// dfr_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dfr_front.sv
// dfr_front: accepts received bytes, writes the frame store, tracks the trailer
// and classifies each completed frame; depends on dfr_pkg
module dfr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       stall,
  input  logic [7:0]                 rx_byte,
  output logic                       full,
  output logic                       ram_we,
  output logic [dfr_pkg::CNT_W-1:0]  ram_waddr,
  output logic [7:0]                 ram_wdata,
  output dfr_pkg::cmd_t              cmd
);

  logic [dfr_pkg::CNT_W-1:0] count;
  logic [dfr_pkg::CNT_W-1:0] count_next;
  logic [dfr_pkg::CNT_W:0]   count_inc;
  logic [dfr_pkg::CNT_W-1:0] count_wrap;
  logic [7:0] prev1, prev2, prev3;
  logic [7:0] store0, store1, store2;
  logic [7:0] hdr0_eff, hdr1_eff, len_eff;
  logic       accept;
  logic       trailer;
  dfr_pkg::status_t status;

  assign full   = stall;
  assign accept = push && !full;

  assign count_inc  = {1'b0, count} + {{dfr_pkg::CNT_W{1'b0}}, 1'b1};
  assign count_wrap = (count_inc == (dfr_pkg::CNT_W + 1)'(dfr_pkg::BUFFER_DEPTH)) ?
                      '0 : count_inc[dfr_pkg::CNT_W-1:0];

  // first three store entries, including this transfer's write
  assign hdr0_eff = (count == dfr_pkg::CNT_W'(0)) ? rx_byte : store0;
  assign hdr1_eff = (count == dfr_pkg::CNT_W'(1)) ? rx_byte : store1;
  assign len_eff  = (count == dfr_pkg::CNT_W'(2)) ? rx_byte : store2;

  assign trailer = (prev3 == dfr_pkg::TRL0) && (prev2 == dfr_pkg::TRL1) &&
                   (prev1 == dfr_pkg::TRL2) && (rx_byte == dfr_pkg::TRL3);

  always_comb begin
    if (hdr0_eff != dfr_pkg::HDR0 || hdr1_eff != dfr_pkg::HDR1) begin
      status = dfr_pkg::ST_BAD_HEADER;
    end else if ({1'b0, len_eff} != 9'(count_wrap)) begin
      status = dfr_pkg::ST_BAD_LENBYTE;
    end else if (9'(count_wrap) != 9'(dfr_pkg::FRAME_LEN)) begin
      status = dfr_pkg::ST_BAD_SIZE;
    end else begin
      status = dfr_pkg::ST_FRAME;
    end
  end

  assign count_next = trailer ? '0 : count_wrap;

  assign ram_we     = accept;
  assign ram_waddr  = count;
  assign ram_wdata  = rx_byte;
  assign cmd.valid  = accept && trailer;
  assign cmd.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      prev1  <= '0;
      prev2  <= '0;
      prev3  <= '0;
      store0 <= '0;
      store1 <= '0;
      store2 <= '0;
    end else if (accept) begin
      count  <= count_next;
      prev1  <= rx_byte;
      prev2  <= prev1;
      prev3  <= prev2;
      store0 <= hdr0_eff;
      store1 <= hdr1_eff;
      store2 <= len_eff;
    end
  end

endmodule

FILE: sv/dfr_cmdq.sv
// dfr_cmdq: two-entry queue of frame verdicts between front and back
// depends on dfr_pkg
module dfr_cmdq (
  input  logic              clk,
  input  logic              rst,
  input  dfr_pkg::cmd_t     cmd,
  input  logic              pop,
  output logic              nonempty,
  output logic              q_full,
  output logic              has_good,
  output dfr_pkg::status_t  head
);

  dfr_pkg::status_t entry [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       do_pop;

  assign nonempty = (fill != 2'd0);
  assign q_full   = (fill == 2'd2);
  assign head     = entry[rd_ptr];
  assign do_pop   = pop && nonempty;

  // a waiting good frame still needs the store untouched
  assign has_good = (nonempty && entry[rd_ptr] == dfr_pkg::ST_FRAME) ||
                    (q_full && entry[!rd_ptr] == dfr_pkg::ST_FRAME);

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      entry[wr_ptr] <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (cmd.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (cmd.valid && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (!cmd.valid && do_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: sv/dfr_back.sv
// dfr_back: turns verdicts into results, walking the store for a good frame,
// and holds the result register; depends on dfr_pkg
module dfr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_nonempty,
  input  dfr_pkg::status_t           q_head,
  output logic                       q_pop,
  output logic                       busy,
  output logic                       ram_re,
  output logic [dfr_pkg::CNT_W-1:0]  ram_raddr,
  input  logic [7:0]                 ram_rdata,
  input  logic                       pop,
  output logic                       empty,
  output logic [1:0]                 status,
  output logic [7:0]                 data_byte,
  output logic                       last
);

  dfr_pkg::back_state_t      state, state_next;
  logic [dfr_pkg::IDX_W-1:0] idx, idx_next;
  logic                      out_valid;
  logic                      slot_free;
  logic                      load;
  logic [1:0]                load_status;
  logic [7:0]                load_data;
  logic                      load_last;
  logic                      idx_last;

  assign slot_free = !out_valid || pop;
  assign idx_last  = (idx == dfr_pkg::IDX_W'(dfr_pkg::FRAME_LEN - 1));
  assign busy      = (state != dfr_pkg::BK_IDLE);
  assign ram_raddr = dfr_pkg::CNT_W'(idx);
  assign empty     = !out_valid;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    q_pop       = 1'b0;
    ram_re      = 1'b0;
    load        = 1'b0;
    load_status = dfr_pkg::ST_FRAME;
    load_data   = '0;
    load_last   = 1'b0;
    case (state)
      dfr_pkg::BK_IDLE: begin
        if (q_nonempty) begin
          if (q_head == dfr_pkg::ST_FRAME) begin
            q_pop      = 1'b1;
            idx_next   = '0;
            state_next = dfr_pkg::BK_READ;
          end else if (slot_free) begin
            q_pop       = 1'b1;
            load        = 1'b1;
            load_status = q_head;
            load_last   = 1'b1;
          end
        end
      end
      dfr_pkg::BK_READ: begin
        ram_re     = 1'b1;
        state_next = dfr_pkg::BK_LOAD;
      end
      dfr_pkg::BK_LOAD: begin
        if (slot_free) begin
          load      = 1'b1;
          load_data = ram_rdata;
          load_last = idx_last;
          if (idx_last) begin
            state_next = dfr_pkg::BK_IDLE;
          end else begin
            idx_next   = idx + dfr_pkg::IDX_W'(1);
            state_next = dfr_pkg::BK_READ;
          end
        end
      end
      default: begin
        state_next = dfr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dfr_pkg::BK_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status    <= load_status;
      data_byte <= load_data;
      last      <= load_last;
    end
  end

endmodule

FILE: sv/delimited_frame_receiver.sv
// delimited_frame_receiver: top level of the byte-framed receiver
// depends on dfr_pkg, dfr_ram, dfr_front, dfr_cmdq, dfr_back
//
//   channel   ports                          transfer when
//   input     push, full, rx_byte            push && !full
//   result    empty, pop, status,            pop && !empty
//             data_byte, last
//
// a byte that ends a bad frame adds one result through the verdict queue and
// the back end's result register, once that register has room
// a good frame drains one byte per pass through the back end's read and
// load states, each load waiting for a free result slot; full stays high until the drain ends
// full is also high while the two-entry verdict queue is full
// rst is synchronous; the store needs no clearing pass, a good frame only
// reads entries written since its count last restarted
module delimited_frame_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] status,
  output logic [7:0] data_byte,
  output logic       last
);

  logic                      ram_we;
  logic [dfr_pkg::CNT_W-1:0] ram_waddr;
  logic [7:0]                ram_wdata;
  logic                      ram_re;
  logic [dfr_pkg::CNT_W-1:0] ram_raddr;
  logic [7:0]                ram_rdata;
  dfr_pkg::cmd_t             cmd;
  dfr_pkg::status_t          q_head;
  logic                      q_nonempty;
  logic                      q_full;
  logic                      q_has_good;
  logic                      q_pop;
  logic                      back_busy;
  logic                      stall;

  // hold off new bytes while the verdict queue is full or a good frame still has to be read out
  assign stall = q_full || q_has_good || back_busy;

  dfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .stall     (stall),
    .rx_byte   (rx_byte),
    .full      (full),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .cmd       (cmd)
  );

  dfr_ram #(
    .WIDTH (8),
    .DEPTH (dfr_pkg::BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dfr_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .q_full   (q_full),
    .has_good (q_has_good),
    .head     (q_head)
  );

  dfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .busy       (back_busy),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .pop        (pop),
    .empty      (empty),
    .status     (status),
    .data_byte  (data_byte),
    .last       (last)
  );

endmodule

FILE: test/delimited_frame_receiver_tb.sv
// delimited_frame_receiver_tb: self-checking testbench of the delimited frame receiver
// feeds framed and broken byte streams, predicts every result and checks each transfer
// depends on dfr_pkg and delimited_frame_receiver
`timescale 1ns / 1ps

module delimited_frame_receiver_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 64;
  localparam int TARGET_BYTES = 370;

  typedef struct {
    dfr_pkg::status_t status;
    logic [7:0]       data;
    logic             last;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic       last;

  // predictor state
  logic [7:0] frame_mem [dfr_pkg::BUFFER_DEPTH];
  int         byte_cnt;
  logic [7:0] hist1, hist2, hist3;

  frame_result_t pending_results[$];

  int  cycle_cnt = 0;
  int  err_cnt = 0;
  int  bytes_sent = 0;
  int  frame_bytes_seen = 0;
  int  good_frames_seen = 0;
  int  status_seen = 0;
  bit  push_idle = 1'b1;
  bit  pop_idle = 1'b1;

  delimited_frame_receiver i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .data_byte (data_byte),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void add_result(input dfr_pkg::status_t st, input logic [7:0] d,
                                     input logic l);
    frame_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    pending_results.push_back(r);
  endfunction

  // store the byte, advance the count, and on a completed trailer judge the frame
  function automatic void predict_frame_results(input logic [7:0] b);
    logic is_trailer;
    frame_mem[byte_cnt] = b;
    byte_cnt = (byte_cnt + 1 >= dfr_pkg::BUFFER_DEPTH) ? 0 : byte_cnt + 1;
    is_trailer = (hist3 == dfr_pkg::TRL0) && (hist2 == dfr_pkg::TRL1) &&
                 (hist1 == dfr_pkg::TRL2) && (b == dfr_pkg::TRL3);
    if (is_trailer) begin
      if (frame_mem[0] != dfr_pkg::HDR0 || frame_mem[1] != dfr_pkg::HDR1) begin
        add_result(dfr_pkg::ST_BAD_HEADER, 8'h00, 1'b1);
      end else if (int'(frame_mem[2]) != byte_cnt) begin
        add_result(dfr_pkg::ST_BAD_LENBYTE, 8'h00, 1'b1);
      end else if (byte_cnt != dfr_pkg::FRAME_LEN) begin
        add_result(dfr_pkg::ST_BAD_SIZE, 8'h00, 1'b1);
      end else begin
        for (int i = 0; i < dfr_pkg::FRAME_LEN && i < dfr_pkg::BUFFER_DEPTH; i++)
          add_result(dfr_pkg::ST_FRAME, frame_mem[i], (i == dfr_pkg::FRAME_LEN - 1));
      end
      byte_cnt = 0;
    end
    hist3 = hist2;
    hist2 = hist1;
    hist1 = b;
  endfunction

  // one input transfer; push stays high when the next byte follows without a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 31) == 0) push_idle = !push_idle;
    gap = push_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_frame_results(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
                            input logic [7:0] len_byte, input int body_len);
    logic [7:0] fill;
    send_byte(h0);
    send_byte(h1);
    send_byte(len_byte);
    for (int i = 0; i < body_len; i++) begin
      fill = 8'($urandom_range(0, 255));
      send_byte(fill);
    end
    send_byte(dfr_pkg::TRL0);
    send_byte(dfr_pkg::TRL1);
    send_byte(dfr_pkg::TRL2);
    send_byte(dfr_pkg::TRL3);
  endtask

  // good frame with the byte extremes in its body
  task automatic test_good_frame;
    send_byte(dfr_pkg::HDR0);
    send_byte(dfr_pkg::HDR1);
    send_byte(8'(dfr_pkg::FRAME_LEN));
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFE);
    send_byte(8'h00);
    send_byte(dfr_pkg::TRL0);
    send_byte(dfr_pkg::TRL1);
    send_byte(dfr_pkg::TRL2);
    send_byte(dfr_pkg::TRL3);
  endtask

  // header wrong in the second byte, length and size also wrong: header wins
  task automatic test_bad_header;
    send_frame(dfr_pkg::HDR0, 8'h00, 8'hFF, 0);
  endtask

  // good header, length byte disagrees with the count
  task automatic test_bad_length_byte;
    send_frame(dfr_pkg::HDR0, dfr_pkg::HDR1, 8'hFF, 0);
  endtask

  // length byte matches the count but the frame is too short
  task automatic test_bad_size;
    send_frame(dfr_pkg::HDR0, dfr_pkg::HDR1, 8'd7, 0);
  endtask

  // frame longer than the store, so the count wraps before the trailer
  task automatic test_count_wrap;
    send_frame(dfr_pkg::HDR0, dfr_pkg::HDR1, 8'(dfr_pkg::FRAME_LEN),
               dfr_pkg::BUFFER_DEPTH - 2);
  endtask

  // well-formed frames with random content, mixed with noise and broken frames
  task automatic test_random_frames;
    int         kind;
    int         n;
    logic [7:0] b;
    while (bytes_sent < TARGET_BYTES) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          send_frame(dfr_pkg::HDR0, dfr_pkg::HDR1, 8'(dfr_pkg::FRAME_LEN),
                     dfr_pkg::FRAME_LEN - 7);
        end
        4: begin
          b = dfr_pkg::HDR0 ^ (8'h01 << $urandom_range(0, 7));
          send_frame(b, dfr_pkg::HDR1, 8'(dfr_pkg::FRAME_LEN), dfr_pkg::FRAME_LEN - 7);
        end
        5: begin
          b = 8'($urandom_range(0, 255));
          send_frame(dfr_pkg::HDR0, (b == dfr_pkg::HDR1) ? 8'h00 : b,
                     8'(dfr_pkg::FRAME_LEN), dfr_pkg::FRAME_LEN - 7);
        end
        6: begin
          n = $urandom_range(0, 20);
          b = 8'($urandom_range(0, 255));
          if (int'(b) == n + 7) b = b + 8'd1;
          send_frame(dfr_pkg::HDR0, dfr_pkg::HDR1, b, n);
        end
        7: begin
          n = $urandom_range(0, 30);
          if (n + 7 == dfr_pkg::FRAME_LEN) n = n + 1;
          send_frame(dfr_pkg::HDR0, dfr_pkg::HDR1, 8'(n + 7), n);
        end
        8: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
          end
        end
        default: begin
          // trailer broken in its last byte
          send_byte(dfr_pkg::TRL0);
          send_byte(dfr_pkg::TRL1);
          send_byte(dfr_pkg::TRL2);
          b = 8'($urandom_range(0, 255));
          send_byte((b == dfr_pkg::TRL3) ? 8'h0B : b);
        end
      endcase
    end
  endtask

  initial begin : result_checker
    frame_result_t want;
    int            gap;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 15) == 0) pop_idle = !pop_idle;
      gap = pop_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d data_byte %0h last %0b",
               status, data_byte, last);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          err_cnt++;
        end
        if (data_byte !== want.data) begin
          $error("data_byte: expected %0h, actual %0h", want.data, data_byte);
          err_cnt++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last);
          err_cnt++;
        end
        if (want.status == dfr_pkg::ST_FRAME) begin
          frame_bytes_seen++;
          if (want.last) good_frames_seen++;
        end else begin
          status_seen++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < dfr_pkg::BUFFER_DEPTH; i++) frame_mem[i] = 8'h00;
    byte_cnt = 0;
    hist1 = 8'h00;
    hist2 = 8'h00;
    hist3 = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_good_frame;
    test_bad_header;
    test_bad_length_byte;
    test_bad_size;
    test_count_wrap;
    test_random_frames;

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes; checked %0d good frames (%0d frame bytes) and %0d status results",
             bytes_sent, good_frames_seen, frame_bytes_seen, status_seen);
    $display("covered bad header, length byte, size, count wrap and broken trailers");
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
